// ===== hw/rtl/rgc_pkg.sv =====
// Shared types, register indexes and log-domain constant tables for the RGB gamma block.
// Used by rgc_csr, rgc_lane and the rgb_gamma_correction top level; depends on nothing.
`default_nettype none
package rgc_pkg;

   // Widths of the stream fields and of the exponent registers.
   localparam int COMP_W   = 8;
   localparam int GAMMA_W  = 15;
   localparam int LOG_W    = 60;   // unsigned Q4.56 log2 values
   localparam int EXP_W    = 62;   // unsigned Q6.56 exponent product
   localparam int SEARCH_N = 8;    // one stage per result bit
   localparam int LANE_DEPTH = 3 + SEARCH_N;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_GAMMA_RED   = 2'd0;
   localparam logic [1:0] REG_GAMMA_GREEN = 2'd1;
   localparam logic [1:0] REG_GAMMA_BLUE  = 2'd2;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = 15'd4096;

   typedef logic [LOG_W-1:0] ltab_type [256];

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   // Truncated Q2.62 product, only evaluated while building the tables.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   // log2 of n in Q.56 by repeated squaring of the mantissa.
   function automatic logic [LOG_W-1:0] log2_q56(input logic [8:0] n);
      logic [63:0]      m;
      logic [LOG_W-1:0] acc;
      int               e;
      e = 0;
      for (int i = 1; i <= 8; i++) begin
         if ((n >> i) != 9'd0) e = i;
      end
      m   = 64'(n) << (62 - e);
      acc = LOG_W'(e) << 56;
      for (int i = 1; i <= 56; i++) begin
         m = mul_q62(m, m);
         if (m[63]) begin
            acc[56-i] = 1'b1;
            m = m >> 1;
         end
      end
      return acc;
   endfunction

   // log2(255) - log2(c) for every nonzero component.
   function automatic ltab_type build_log_diff();
      ltab_type         t;
      logic [LOG_W-1:0] top;
      top  = log2_q56(9'd255);
      t[0] = '0;
      for (int c = 1; c < 256; c++) t[c] = top - log2_q56(9'(c));
      return t;
   endfunction

   // Threshold for result k: log2(510) - log2(2k-1).
   function automatic ltab_type build_thresh();
      ltab_type         t;
      logic [LOG_W-1:0] top;
      top  = log2_q56(9'd510);
      t[0] = '0;
      for (int k = 1; k < 256; k++) t[k] = top - log2_q56(9'(2 * k - 1));
      return t;
   endfunction

   localparam ltab_type LOG_DIFF = build_log_diff();
   localparam ltab_type THRESH   = build_thresh();

endpackage
`default_nettype wire

// ===== hw/rtl/rgc_csr.sv =====
// Exponent register file of the RGB gamma block, written over the configuration port.
// Depends on rgc_pkg.
`default_nettype none
module rgc_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [rgc_pkg::GAMMA_W-1:0]  csr_data,
   output logic [rgc_pkg::GAMMA_W-1:0]       gamma_red,
   output logic [rgc_pkg::GAMMA_W-1:0]       gamma_green,
   output logic [rgc_pkg::GAMMA_W-1:0]       gamma_blue
);

   logic [rgc_pkg::GAMMA_W-1:0] red_ff, green_ff, blue_ff;
   logic                        wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   // Each register takes the data when its index is written; other indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= rgc_pkg::GAMMA_RESET;
         green_ff <= rgc_pkg::GAMMA_RESET;
         blue_ff  <= rgc_pkg::GAMMA_RESET;
      end else if (wr) begin
         if (csr_index == rgc_pkg::REG_GAMMA_RED)   red_ff   <= csr_data;
         if (csr_index == rgc_pkg::REG_GAMMA_GREEN) green_ff <= csr_data;
         if (csr_index == rgc_pkg::REG_GAMMA_BLUE)  blue_ff  <= csr_data;
      end
   end

   assign gamma_red   = red_ff;
   assign gamma_green = green_ff;
   assign gamma_blue  = blue_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rgc_lane.sv =====
// One color channel: log lookup, exponent multiply and an 8-stage pipelined binary search.
// Depends on rgc_pkg; instantiated three times by rgb_gamma_correction.
`default_nettype none
module rgc_lane (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [rgc_pkg::COMP_W-1:0]   comp_in,
   input  wire logic [rgc_pkg::GAMMA_W-1:0]  gamma_in,
   output logic [rgc_pkg::COMP_W-1:0]        result_out
);

   localparam int N = rgc_pkg::SEARCH_N;

   // Stage 1: log distance from full scale.
   logic [rgc_pkg::LOG_W-1:0]   lval_ff;
   logic [rgc_pkg::GAMMA_W-1:0] g_ff;
   logic [1:0]                  sp1_ff;   // {component is zero, gamma is zero}

   always_ff @(posedge clock) begin
      if (en) begin
         lval_ff <= rgc_pkg::LOG_DIFF[comp_in];
         g_ff    <= gamma_in;
         sp1_ff  <= {comp_in == '0, gamma_in == '0};
      end
   end

   // Stage 2: two partial products of log distance and gamma.
   logic [rgc_pkg::LOG_W-32+rgc_pkg::GAMMA_W-1:0] phi_ff;
   logic [32+rgc_pkg::GAMMA_W-1:0]                plo_ff;
   logic [1:0]                                    sp2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         phi_ff <= lval_ff[rgc_pkg::LOG_W-1:32] * g_ff;
         plo_ff <= lval_ff[31:0] * g_ff;
         sp2_ff <= sp1_ff;
      end
   end

   // Stage 3: exponent product in Q.56, truncated after the Q3.12 scaling.
   logic [rgc_pkg::EXP_W-1:0] e_ff;
   logic [1:0]                sp3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff   <= rgc_pkg::EXP_W'({phi_ff, 20'b0}) + rgc_pkg::EXP_W'(plo_ff >> 12);
         sp3_ff <= sp2_ff;
      end
   end

   // Search stages: stage j decides bit 7-j of the result against one threshold.
   logic [rgc_pkg::EXP_W-1:0]  es_ff [N];
   logic [rgc_pkg::COMP_W-1:0] k_ff  [N];
   logic [1:0]                 sp_ff [N];

   for (genvar j = 0; j < N; j++) begin : g_step
      logic [rgc_pkg::EXP_W-1:0]  e_prev;
      logic [rgc_pkg::COMP_W-1:0] k_prev, cand, k_in;
      logic [1:0]                 sp_prev;

      if (j == 0) begin : g_first
         assign e_prev  = e_ff;
         assign k_prev  = '0;
         assign sp_prev = sp3_ff;
      end else begin : g_next
         assign e_prev  = es_ff[j-1];
         assign k_prev  = k_ff[j-1];
         assign sp_prev = sp_ff[j-1];
      end

      assign cand = k_prev | rgc_pkg::COMP_W'(1 << (N - 1 - j));
      assign k_in = (e_prev <= rgc_pkg::EXP_W'(rgc_pkg::THRESH[cand])) ? cand : k_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            es_ff[j] <= e_prev;
            k_ff[j]  <= k_in;
            sp_ff[j] <= sp_prev;
         end
      end
   end

   // A zero component bypasses the search: 255 under zero gamma, else 0.
   always_comb begin
      if (sp_ff[N-1][1]) result_out = sp_ff[N-1][0] ? '1 : '0;
      else               result_out = k_ff[N-1];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_gamma_correction.sv =====
// Top level of the RGB gamma block: three channel lanes, a valid pipeline and the output register.
// Depends on rgc_pkg, rgc_csr and rgc_lane.
//
//  channel | ports                       | contents
//  --------+-----------------------------+------------------------------------------
//  req     | req_tvalid/tready/tdata/tlast | source pixel, tlast = frame end
//  rsp     | rsp_tvalid/tready/tdata/tlast | corrected pixel, tlast = frame end
//  csr     | csr_valid/ready/index/data  | exponent writes, index 0 red, 1 green, 2 blue
//
// One pixel enters per clock unless rsp stalls; its result passes through 11 lane
// stages and the output register. The whole pipeline advances together whenever the
// output register is empty or being read, so a stall on rsp holds every stage.
// Reset clears all valid flags and loads each exponent with 1.0 (4096).
`default_nettype none
module rgb_gamma_correction (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [23:0]                  req_tdata,   // red_in, green_in, blue_in
   input  wire logic                         req_tlast,   // frame_end_in
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [23:0]                       rsp_tdata,   // red_out, green_out, blue_out
   output logic                              rsp_tlast,   // frame_end_out
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [rgc_pkg::GAMMA_W-1:0]  csr_data
);

   localparam int D = rgc_pkg::LANE_DEPTH;

   logic [rgc_pkg::GAMMA_W-1:0] gamma_red, gamma_green, gamma_blue;
   rgc_pkg::pixel_type          lane_res;
   logic                        en;

   rgc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .gamma_red   (gamma_red),
      .gamma_green (gamma_green),
      .gamma_blue  (gamma_blue)
   );

   // Pipeline moves when the output register can take a new transaction.
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   rgc_lane u_lane_red (
      .clock (clock), .en (en), .comp_in (req_tdata[7:0]),
      .gamma_in (gamma_red), .result_out (lane_res.red)
   );
   rgc_lane u_lane_green (
      .clock (clock), .en (en), .comp_in (req_tdata[15:8]),
      .gamma_in (gamma_green), .result_out (lane_res.green)
   );
   rgc_lane u_lane_blue (
      .clock (clock), .en (en), .comp_in (req_tdata[23:16]),
      .gamma_in (gamma_blue), .result_out (lane_res.blue)
   );

   // Valid flags and frame-end markers travel alongside the lanes.
   logic [D-1:0] vld_ff, vld_in;
   logic [D-1:0] last_ff;

   assign vld_in = {vld_ff[D-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset)   vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) last_ff <= {last_ff[D-2:0], req_tlast};
   end

   // Output register merges the three lanes into one transaction.
   logic        out_vld_ff;
   logic [23:0] out_data_ff;
   logic        out_last_ff;

   always_ff @(posedge clock) begin
      if (reset)   out_vld_ff <= 1'b0;
      else if (en) out_vld_ff <= vld_ff[D-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {lane_res.blue, lane_res.green, lane_res.red};
         out_last_ff <= last_ff[D-1];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rgc_checker.sv =====
// Port-level checks for rgb_gamma_correction and the bind that attaches them.
// Depends on rgb_gamma_correction.
`default_nettype none
module rgc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Input is taken whenever the output register is free or being drained.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input blocked while output can move");

   // Input is held off only while a result waits.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output back-pressure");

endmodule

bind rgb_gamma_correction rgc_checker u_rgc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
